### sv/acd_pkg.sv
// Shared constants and command codes for the axis calibration and dead-zone block.
// No dependencies; imported by axis_calibrate_deadzone.
`timescale 1ns / 1ps

package acd_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 16;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic [1:0] {
    CMD_SAMPLE   = 2'd0,
    CMD_BEGIN    = 2'd1,
    CMD_FINISH   = 2'd2,
    CMD_RECENTER = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_CENTER   = 1'b0,
    REG_DEADZONE = 1'b1
  } reg_e;

endpackage

### sv/axis_calibrate_deadzone.sv
// Axis calibration with a center dead zone: bit-serial gain divider and mapping multiplier.
// Depends on acd_pkg for parameter defaults, APB widths and command codes.
//
//   channel   signals                                   direction
//   input     in_valid_i, in_stall_o, command_i,        in
//             raw_sample_i
//   output    out_valid_o, out_stall_i, axis_value_o    out
//   config    psel, penable, pwrite, paddr, pwdata,     in / out
//             prdata, pready
//
// A mapped sample runs through the shift-add multiplier (one multiplier bit per cycle)
// before the emit step; inside the dead zone or at or below the seen minimum, it goes straight
// to the emit step. A calibration sample or a recenter that passes its range check runs
// the two restoring dividers that work side by side one quotient bit per cycle.
// Other commands and a refused recenter leave the block idle.
// Reset needs no clearing pass. A finished item waits in the output register while the next
// item is accepted; stall on the output holds the emit step once a second result is ready.
`timescale 1ns / 1ps

module axis_calibrate_deadzone #(
  parameter int SAMPLE_BITS    = acd_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = acd_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  acd_pkg::cmd_e                 command_i,
  input  logic signed [SAMPLE_BITS-1:0] raw_sample_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] axis_value_o,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acd_pkg::APB_AW-1:0]    paddr,
  input  logic [acd_pkg::APB_DW-1:0]    pwdata,
  output logic [acd_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  import acd_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int F  = GAIN_FRAC_BITS;
  localparam int G  = F + 8;
  localparam int W  = S + 2;
  localparam int CW = $clog2(S + F + 1);

  localparam logic [S-1:0] SMP_MIN    = {1'b1, {(S-1){1'b0}}};
  localparam logic [S-1:0] SMP_MAX    = {1'b0, {(S-1){1'b1}}};
  localparam logic [G-1:0] GAIN_UNITY = {7'd0, 1'b1, {F{1'b0}}};
  localparam logic [G-1:0] GAIN_MAX   = {G{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT,
    ST_DSET,
    ST_DIV
  } state_e;

  state_e          state_q;
  logic [S-1:0]    center_q;
  logic [S-2:0]    dz_q;
  logic [S-1:0]    min_q, max_q;
  logic [G-1:0]    gain_lo_q, gain_hi_q;
  logic            cal_q;
  logic [CW-1:0]   cnt_q;
  logic [G-1:0]    ph_q;
  logic [S-1:0]    pl_q;
  logic            side_low_q;
  logic            use_prod_q;
  logic [S-1:0]    res_q;
  logic            out_valid_q;
  logic [S-1:0]    axis_q;
  logic [S-1:0]    rem_lo_q, rem_hi_q, div_lo_q, div_hi_q;
  logic [G-1:0]    quo_lo_q, quo_hi_q;
  logic            ovf_lo_q, ovf_hi_q, ok_lo_q, ok_hi_q;

  logic                cfg_wr;
  logic                in_acc;
  logic signed [W-1:0] x_w, c_w, dz_w, min_w, max_w;
  logic signed [W-1:0] lo_edge, hi_edge, off_lo, off_hi, den_lo, den_hi;
  logic                below, above, off_lo_pos, recenter_ok;
  logic [G:0]          mul_sum;
  logic [G+S-1:0]      prod;
  logic [S+7:0]        prod_sh;
  logic [S-1:0]        prod_res;
  logic                numbit;
  logic [S:0]          rsh_lo, rsh_hi, rdf_lo, rdf_hi;
  logic                geq_lo, geq_hi;
  logic [S-1:0]        rnx_lo, rnx_hi;

  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign axis_value_o = axis_q;

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_CENTER:   prdata = {{(APB_DW-S){center_q[S-1]}}, center_q};
      REG_DEADZONE: prdata = {{(APB_DW-S+1){1'b0}}, dz_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      dz_q     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_CENTER:   center_q <= pwdata[S-1:0];
        REG_DEADZONE: dz_q     <= pwdata[S-2:0];
      endcase
    end
  end

  always_comb begin
    x_w     = {{2{raw_sample_i[S-1]}}, raw_sample_i};
    c_w     = {{2{center_q[S-1]}}, center_q};
    dz_w    = {3'd0, dz_q};
    min_w   = {{2{min_q[S-1]}}, min_q};
    max_w   = {{2{max_q[S-1]}}, max_q};
    lo_edge = c_w - dz_w;
    hi_edge = c_w + dz_w;
    off_lo  = x_w - min_w;
    off_hi  = x_w - hi_edge;
    den_lo  = lo_edge - min_w;
    den_hi  = max_w - hi_edge;
    below   = x_w < lo_edge;
    above   = x_w > hi_edge;
    off_lo_pos  = !off_lo[W-1] && (off_lo != '0);
    recenter_ok = (center_q != SMP_MIN) && (center_q != SMP_MAX) && !dz_q[S-2];
  end

  // shift-add multiply, multiplier bits leave pl_q as product bits enter
  always_comb begin
    mul_sum = {1'b0, ph_q} + (pl_q[0] ? {1'b0, (side_low_q ? gain_lo_q : gain_hi_q)} : '0);
    prod    = {ph_q, pl_q};
    prod_sh = prod[G+S-1:F];
    if (side_low_q) begin
      prod_res = (|prod_sh[S+7:S]) ? SMP_MAX : {~prod_sh[S-1], prod_sh[S-2:0]};
    end else begin
      prod_res = (|prod_sh[S+7:S-1]) ? SMP_MAX : prod_sh[S-1:0];
    end
  end

  // restoring division of 2^(S-1+F); numerator has a single one at its top bit
  always_comb begin
    numbit = (cnt_q == '0);
    rsh_lo = {rem_lo_q, numbit};
    rsh_hi = {rem_hi_q, numbit};
    rdf_lo = rsh_lo - {1'b0, div_lo_q};
    rdf_hi = rsh_hi - {1'b0, div_hi_q};
    geq_lo = rsh_lo >= {1'b0, div_lo_q};
    geq_hi = rsh_hi >= {1'b0, div_hi_q};
    rnx_lo = geq_lo ? rdf_lo[S-1:0] : rsh_lo[S-1:0];
    rnx_hi = geq_hi ? rdf_hi[S-1:0] : rsh_hi[S-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= SMP_MIN;
      max_q       <= SMP_MAX;
      gain_lo_q   <= GAIN_UNITY;
      gain_hi_q   <= GAIN_UNITY;
      cal_q       <= 1'b0;
      cnt_q       <= '0;
      ph_q        <= '0;
      pl_q        <= '0;
      side_low_q  <= 1'b0;
      use_prod_q  <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      axis_q      <= '0;
      rem_lo_q    <= '0;
      rem_hi_q    <= '0;
      div_lo_q    <= '0;
      div_hi_q    <= '0;
      quo_lo_q    <= '0;
      quo_hi_q    <= '0;
      ovf_lo_q    <= 1'b0;
      ovf_hi_q    <= 1'b0;
      ok_lo_q     <= 1'b0;
      ok_hi_q     <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (command_i)
              CMD_SAMPLE: begin
                if (cal_q) begin
                  if (x_w < min_w) begin
                    min_q <= raw_sample_i;
                  end
                  if (x_w > max_w) begin
                    max_q <= raw_sample_i;
                  end
                  state_q <= ST_DSET;
                end else if (below) begin
                  if (off_lo_pos) begin
                    pl_q       <= off_lo[S-1:0];
                    ph_q       <= '0;
                    side_low_q <= 1'b1;
                    use_prod_q <= 1'b1;
                    cnt_q      <= '0;
                    state_q    <= ST_MUL;
                  end else begin
                    res_q      <= SMP_MIN;
                    use_prod_q <= 1'b0;
                    state_q    <= ST_EMIT;
                  end
                end else if (above) begin
                  pl_q       <= off_hi[S-1:0];
                  ph_q       <= '0;
                  side_low_q <= 1'b0;
                  use_prod_q <= 1'b1;
                  cnt_q      <= '0;
                  state_q    <= ST_MUL;
                end else begin
                  res_q      <= '0;
                  use_prod_q <= 1'b0;
                  state_q    <= ST_EMIT;
                end
              end
              CMD_BEGIN: begin
                if (!cal_q) begin
                  cal_q     <= 1'b1;
                  min_q     <= SMP_MAX;
                  max_q     <= SMP_MIN;
                  gain_lo_q <= GAIN_UNITY;
                  gain_hi_q <= GAIN_UNITY;
                end
              end
              CMD_FINISH: begin
                cal_q <= 1'b0;
              end
              CMD_RECENTER: begin
                if (recenter_ok) begin
                  state_q <= ST_DSET;
                end
              end
            endcase
          end
        end
        ST_MUL: begin
          ph_q  <= mul_sum[G:1];
          pl_q  <= {mul_sum[0], pl_q[S-1:1]};
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(S - 1)) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            axis_q      <= use_prod_q ? prod_res : res_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_DSET: begin
          ok_lo_q  <= !den_lo[W-1] && (den_lo != '0);
          ok_hi_q  <= !den_hi[W-1] && (den_hi != '0);
          div_lo_q <= den_lo[S-1:0];
          div_hi_q <= den_hi[S-1:0];
          rem_lo_q <= '0;
          rem_hi_q <= '0;
          quo_lo_q <= '0;
          quo_hi_q <= '0;
          ovf_lo_q <= 1'b0;
          ovf_hi_q <= 1'b0;
          cnt_q    <= '0;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          rem_lo_q <= rnx_lo;
          rem_hi_q <= rnx_hi;
          quo_lo_q <= {quo_lo_q[G-2:0], geq_lo};
          quo_hi_q <= {quo_hi_q[G-2:0], geq_hi};
          ovf_lo_q <= ovf_lo_q | quo_lo_q[G-1];
          ovf_hi_q <= ovf_hi_q | quo_hi_q[G-1];
          cnt_q    <= cnt_q + CW'(1);
          if (cnt_q == CW'(S + F - 1)) begin
            gain_lo_q <= !ok_lo_q ? GAIN_UNITY :
                         (ovf_lo_q | quo_lo_q[G-1]) ? GAIN_MAX : {quo_lo_q[G-2:0], geq_lo};
            gain_hi_q <= !ok_hi_q ? GAIN_UNITY :
                         (ovf_hi_q | quo_hi_q[G-1]) ? GAIN_MAX : {quo_hi_q[G-2:0], geq_hi};
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
